// File: src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared sizes, action codes and the control/status bundles that pass
// between the positional list controller and its datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;
  localparam int ACT_W    = 3;
  localparam int LEN_W    = 7;
  // compare width for (position - 1) against the fill count
  localparam int CMP_W    = (FILL_W > POS_W - 1) ? FILL_W : POS_W - 1;

  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

  // memory read address selects
  localparam logic [2:0] RD_IDX    = 3'd0;
  localparam logic [2:0] RD_PTR_M1 = 3'd1;
  localparam logic [2:0] RD_PTR_M2 = 3'd2;
  localparam logic [2:0] RD_PTR_P1 = 3'd3;
  localparam logic [2:0] RD_PTR_P2 = 3'd4;

  typedef struct packed {
    logic       load_cmd;  // latch the accepted item
    logic       eval;      // decide ok, index and start pointer
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_move;   // write read data at pointer
    logic       wr_new;    // write new value at index
    logic       ptr_inc;
    logic       ptr_dec;
    logic       rd_cap;    // capture read data as result value
    logic       fill_inc;
    logic       fill_dec;
    logic       fill_clr;
    logic       res_load;  // load the output register
  } ple_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             ok;
    logic             ptr_at_idx;
    logic             ptr_m1_at_idx;
    logic             dn_last;   // ptr + 1 == fill
    logic             dn_last2;  // ptr + 2 == fill
    logic             out_free;
  } ple_stat_t;

endpackage

// File: src/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp
// Datapath: command registers, entry memory, shift pointer, fill count
// and the output result register.
// ----------------------------------------------------------------------------
module ple_dp
  import ple_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ple_cmd_t                 cmd,
  output ple_stat_t                stat,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic signed [POS_W-1:0]  in_position,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [LEN_W-1:0]         out_length
);

  logic [ACT_W-1:0]         act_r;
  logic [DATA_W-1:0]        value_r;
  logic signed [POS_W-1:0]  pos_r;
  logic                     ok_r;
  logic [ADDR_W-1:0]        idx_r;
  logic [ADDR_W-1:0]        ptr_r;
  logic [FILL_W-1:0]        fill_r;
  logic [DATA_W-1:0]        rdata_r;
  logic [DATA_W-1:0]        rd_r;
  logic [DATA_W-1:0]        mem [CAPACITY];

  logic                     out_tvalid_r;
  logic                     out_ok_r;
  logic [DATA_W-1:0]        out_rd_r;
  logic [LEN_W-1:0]         out_len_r;

  logic [CMP_W-1:0]         fill_ext;
  logic [CMP_W-1:0]         pos_m1;
  logic                     pos_le1;
  logic                     not_full;
  logic                     ok_nxt;
  logic [ADDR_W-1:0]        idx_nxt;
  logic [ADDR_W-1:0]        raddr;
  logic [FILL_W-1:0]        ptr_ext;

  assign fill_ext = CMP_W'(fill_r);
  assign pos_m1   = CMP_W'(pos_r[POS_W-2:0]) - CMP_W'(1);
  assign pos_le1  = (pos_r <= $signed(POS_W'(1)));
  assign not_full = (fill_r < FILL_W'(CAPACITY));
  assign ptr_ext  = FILL_W'(ptr_r);

  // decide outcome and target index of the latched command
  always_comb begin
    ok_nxt  = 1'b0;
    idx_nxt = ADDR_W'(fill_r);
    case (act_r)
      ACT_APPEND: begin
        ok_nxt = not_full;
      end
      ACT_INSERT: begin
        ok_nxt = not_full;
        if (fill_r == '0 || pos_le1) begin
          idx_nxt = '0;
        end else if (pos_m1 > fill_ext) begin
          idx_nxt = ADDR_W'(fill_r);
        end else begin
          idx_nxt = ADDR_W'(pos_m1);
        end
      end
      ACT_GET: begin
        idx_nxt = pos_le1 ? '0 : ADDR_W'(pos_m1);
        ok_nxt  = !pos_r[POS_W-1] && (fill_r != '0) && (pos_le1 || pos_m1 < fill_ext);
      end
      ACT_REMOVE: begin
        idx_nxt = ADDR_W'(pos_m1);
        ok_nxt  = !pos_r[POS_W-1] && (pos_r != '0) && (pos_m1 < fill_ext);
      end
      ACT_COUNT: ok_nxt = 1'b1;
      ACT_CLEAR: ok_nxt = 1'b1;
      default:   ok_nxt = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    raddr = idx_r;
      RD_PTR_M1: raddr = ptr_r - ADDR_W'(1);
      RD_PTR_M2: raddr = ptr_r - ADDR_W'(2);
      RD_PTR_P1: raddr = ptr_r + ADDR_W'(1);
      RD_PTR_P2: raddr = ptr_r + ADDR_W'(2);
      default:   raddr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      act_r   <= in_action;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd.eval) begin
      ok_r  <= ok_nxt;
      idx_r <= idx_nxt;
      ptr_r <= (act_r == ACT_REMOVE) ? idx_nxt : ADDR_W'(fill_r);
      rd_r  <= '0;
    end else begin
      if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + ADDR_W'(1);
      end else if (cmd.ptr_dec) begin
        ptr_r <= ptr_r - ADDR_W'(1);
      end
      if (cmd.rd_cap) begin
        rd_r <= rdata_r;
      end
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_move) begin
      mem[ptr_r] <= rdata_r;
    end else if (cmd.wr_new) begin
      mem[idx_r] <= value_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.fill_clr) begin
      fill_r <= '0;
    end else if (cmd.fill_inc) begin
      fill_r <= fill_r + FILL_W'(1);
    end else if (cmd.fill_dec) begin
      fill_r <= fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_ok_r  <= ok_r;
      out_rd_r  <= rd_r;
      out_len_r <= LEN_W'(fill_r);
    end
  end

  assign stat.act           = act_r;
  assign stat.ok            = ok_r;
  assign stat.ptr_at_idx    = (ptr_r == idx_r);
  assign stat.ptr_m1_at_idx = ((ptr_r - ADDR_W'(1)) == idx_r);
  assign stat.dn_last       = ((ptr_ext + FILL_W'(1)) == fill_r);
  assign stat.dn_last2      = ((ptr_ext + FILL_W'(2)) == fill_r);
  assign stat.out_free      = !out_tvalid_r || out_tready;

  assign out_tvalid     = out_tvalid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rd_r;
  assign out_length     = out_len_r;

  a_fill_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_inc |-> fill_r < FILL_W'(CAPACITY))
    else $error("fill count grows past capacity");

  a_fill_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_dec |-> fill_r != '0)
    else $error("fill count drops below zero");

  a_res_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_tvalid_r || out_tready))
    else $error("result overwritten before it was taken");

endmodule

// File: src/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller: sequences evaluation, entry moves, reads and result hand-off
// for one command at a time.
// ----------------------------------------------------------------------------
module ple_ctrl
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ple_stat_t stat,
  output ple_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_SHUP  = 3'd3;
  localparam logic [2:0] S_WRNEW = 3'd4;
  localparam logic [2:0] S_SHDN  = 3'd5;
  localparam logic [2:0] S_RDWT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_cmd = 1'b1;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        state_nxt = S_DONE;
        if (stat.ok) begin
          case (stat.act)
            ACT_APPEND, ACT_INSERT: begin
              if (stat.ptr_at_idx) begin
                state_nxt = S_WRNEW;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PTR_M1;
                state_nxt  = S_SHUP;
              end
            end
            ACT_GET: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_IDX;
              state_nxt  = S_RDWT;
            end
            ACT_REMOVE: begin
              if (stat.dn_last) begin
                cmd.fill_dec = 1'b1;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PTR_P1;
                state_nxt  = S_SHDN;
              end
            end
            ACT_CLEAR: cmd.fill_clr = 1'b1;
            default:   cmd.fill_clr = 1'b0;
          endcase
        end
      end
      S_SHUP: begin
        // move entry ptr-1 up to ptr, fetch the next one below
        cmd.wr_move = 1'b1;
        cmd.ptr_dec = 1'b1;
        if (stat.ptr_m1_at_idx) begin
          state_nxt = S_WRNEW;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M2;
        end
      end
      S_WRNEW: begin
        cmd.wr_new   = 1'b1;
        cmd.fill_inc = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SHDN: begin
        // move entry ptr+1 down to ptr, fetch the next one above
        cmd.wr_move = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (stat.dn_last2) begin
          cmd.fill_dec = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_P2;
        end
      end
      S_RDWT: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_shup_not_at_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHUP) |-> !stat.ptr_at_idx)
    else $error("upward shift reached insert index without stopping");

  a_move_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_move || cmd.wr_new) |-> stat.ok)
    else $error("memory written for a refused command");

  a_load_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_cmd |=> (state_r == S_EVAL))
    else $error("accepted item not evaluated next cycle");

endmodule

// File: src/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed words with append, insert, get, remove, count
// and clear by one-based position.
// ----------------------------------------------------------------------------
// Sequence: each accepted item passes S_EVAL and S_DISP to S_DONE, which waits for
//   a free output register. Count, clear, refused commands and removal of the tail
//   entry add no other state; append adds S_WRNEW, get S_RDWT, insert one S_SHUP
//   per entry moved up and remove one S_SHDN per entry moved down, set by the entry
//   memory (one read and one write per cycle). Throughput: one item at a time; the
//   next is accepted the cycle after the result enters the output register.
// Reset clears the fill count and control state; entry memory is not cleared.
module positional_list_engine_core
  import ple_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // value[31:0], position[47:32]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[31:0], length[38:32], zero[39]
  output logic [0:0]  out_tuser   // ok[0]
);

  ple_cmd_t                 cmd;
  ple_stat_t                stat;
  logic                     res_ok;
  logic signed [DATA_W-1:0] res_read_value;
  logic [LEN_W-1:0]         res_length;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ple_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_tuser),
    .in_value       (in_tdata[31:0]),
    .in_position    (in_tdata[47:32]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_ok         (res_ok),
    .out_read_value (res_read_value),
    .out_length     (res_length)
  );

  assign out_tdata = {1'b0, res_length, res_read_value};
  assign out_tuser = res_ok;

endmodule

// File: bench/ple_list_checker.sv
// ----------------------------------------------------------------------------
// ple_list_checker
// Watches both stream channels of the positional list engine, keeps its own
// copy of the list, predicts one result per accepted command and compares
// each returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ple_list_checker
  import ple_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // value[31:0], position[47:32]
  input  logic [2:0]  in_tuser,   // action[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // read_value[31:0], length[38:32], zero[39]
  input  logic [0:0]  out_tuser,  // ok[0]
  output int          mismatches,
  output int          pending,
  output int          cur_len,
  output int          peak_len
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  rd;
    logic [LEN_W-1:0]   len;
  } list_result_t;

  logic [DATA_W-1:0] list_mem [CAPACITY];
  int                list_len;
  int                list_peak;
  int                fail_tally;
  int                result_idx;
  list_result_t      result_q[$];
  list_result_t      want;

  // Apply one command to the shadow list and return the result it gives.
  function automatic list_result_t apply_command(logic [ACT_W-1:0] act,
                                                 logic [DATA_W-1:0] val,
                                                 logic signed [POS_W-1:0] pos);
    int           p;
    int           idx;
    int           i;
    list_result_t r;
    p   = pos;
    idx = 0;
    r   = '0;
    case (act)
      ACT_APPEND, ACT_INSERT: begin
        if (list_len < CAPACITY) begin
          if (act == ACT_APPEND) begin
            idx = list_len;
          end else if (list_len == 0 || p <= 1) begin
            idx = 0;
          end else begin
            idx = (p - 1 > list_len) ? list_len : p - 1;
          end
          for (i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
          list_mem[idx] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      ACT_GET: begin
        if (p >= 0 && list_len != 0) begin
          idx = (p <= 1) ? 0 : p - 1;
          if (idx < list_len) begin
            r.rd = list_mem[idx];
            r.ok = 1'b1;
          end
        end
      end
      ACT_REMOVE: begin
        if (p >= 1 && list_len != 0 && p - 1 < list_len) begin
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      ACT_COUNT: r.ok = 1'b1;
      ACT_CLEAR: begin
        list_len = 0;
        r.ok     = 1'b1;
      end
      default: ;
    endcase
    if (list_len > list_peak) list_peak = list_len;
    r.len = list_len[LEN_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t ns: result %0d: %s got %h, predicted %h", $time, result_idx, what,
             got, exp_val);
    fail_tally++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len   = 0;
      list_peak  = 0;
      fail_tally = 0;
      result_idx = 0;
      result_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(apply_command(in_tuser, in_tdata[31:0], in_tdata[47:32]));
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected item, read_value", out_tdata[31:0], 32'd0);
        end else begin
          want = result_q.pop_front();
          if (out_tuser[0] !== want.ok)
            report_mismatch("ok", 32'(out_tuser[0]), 32'(want.ok));
          if (out_tdata[31:0] !== want.rd)
            report_mismatch("read_value", out_tdata[31:0], want.rd);
          if (out_tdata[38:32] !== want.len)
            report_mismatch("length", 32'(out_tdata[38:32]), 32'(want.len));
        end
        result_idx++;
      end
    end
    mismatches <= fail_tally;
    pending    <= result_q.size();
    cur_len    <= list_len;
    peak_len   <= list_peak;
  end

endmodule

// File: bench/tb_positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine_core
// Drives list commands into the engine: directed corner cases, a fill past
// capacity, then growth, shrinkage and mixed phases with random input gaps
// and output back-pressure. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_core;
  import ple_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = CAPACITY + 40;
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} traffic_phase_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // value[31:0], position[47:32]
  logic [2:0]  in_tuser   = '0;   // action[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // read_value[31:0], length[38:32], zero[39]
  logic [0:0]  out_tuser;         // ok[0]

  logic        no_idle    = 1'b0;
  int          stuck_cycles = 0;
  int          act_count [8];
  int          mismatches;
  int          pending;
  int          cur_len;
  int          peak_len;

  always #10 clk = ~clk;

  positional_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  ple_list_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .mismatches(mismatches),
    .pending   (pending),
    .cur_len   (cur_len),
    .peak_len  (peak_len)
  );

  // Result sink: random back-pressure except during the no-idle stretch.
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Hold the item until accepted; insert random gaps before it.
  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {pos, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    act_count[act]++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 80) return $urandom;
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Bias positions toward the live range and its edges.
  function automatic logic [POS_W-1:0] pick_position(int len);
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(len + 2, 0));
    if (r < 75) return 16'(len - 1 + int'($urandom_range(2)));
    if (r < 85) return 16'(-int'($urandom_range(3)));
    if (r < 95) return 16'($urandom);
    case ($urandom_range(2))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(traffic_phase_t ph);
    int r;
    r = $urandom_range(99);
    if (r < 3) return ($urandom_range(1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
    case (ph)
      PH_GROW: begin
        if (r < 38) return ACT_APPEND;
        if (r < 73) return ACT_INSERT;
        if (r < 88) return ACT_GET;
        if (r < 94) return ACT_REMOVE;
        return ACT_COUNT;
      end
      PH_SHRINK: begin
        if (r < 48) return ACT_REMOVE;
        if (r < 70) return ACT_GET;
        if (r < 80) return ACT_APPEND;
        if (r < 90) return ACT_INSERT;
        if (r < 98) return ACT_COUNT;
        return ACT_CLEAR;
      end
      default: begin
        if (r < 5)  return ACT_CLEAR;
        if (r < 25) return ACT_APPEND;
        if (r < 45) return ACT_INSERT;
        if (r < 70) return ACT_GET;
        if (r < 92) return ACT_REMOVE;
        return ACT_COUNT;
      end
    endcase
  endfunction

  initial begin
    int             rand_sent;
    int             span;
    int             i;
    traffic_phase_t ph;
    rand_sent = 0;
    foreach (act_count[k]) act_count[k] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list, head/tail inserts, position extremes, refused reads/removes.
    send_cmd(ACT_COUNT,    32'd0,          16'd0);
    send_cmd(ACT_GET,      32'd0,          16'd0);
    send_cmd(ACT_REMOVE,   32'd0,          16'd1);
    send_cmd(ACT_INSERT,   32'h7fff_ffff,  16'd7);
    send_cmd(ACT_APPEND,   32'h8000_0000,  16'hffff);
    send_cmd(ACT_INSERT,   32'h0000_0000,  16'h8000);
    send_cmd(ACT_INSERT,   32'hffff_ffff,  16'h7fff);
    send_cmd(ACT_INSERT,   32'h1234_5678,  16'd2);
    send_cmd(ACT_GET,      32'hffff_ffff,  16'd0);
    send_cmd(ACT_GET,      32'd0,          16'd1);
    send_cmd(ACT_GET,      32'd0,          16'hffff);
    send_cmd(ACT_GET,      32'd0,          16'h8000);
    send_cmd(ACT_GET,      32'd0,          16'd5);
    send_cmd(ACT_GET,      32'd0,          16'd6);
    send_cmd(ACT_GET,      32'd0,          16'h7fff);
    send_cmd(ACT_REMOVE,   32'd0,          16'd0);
    send_cmd(ACT_REMOVE,   32'd0,          16'hffff);
    send_cmd(ACT_REMOVE,   32'd0,          16'd6);
    send_cmd(ACT_REMOVE,   32'd0,          16'd5);
    send_cmd(ACT_REMOVE,   32'd0,          16'd1);
    send_cmd(ACT_SPARE_LO, 32'hdead_beef,  16'd1);
    send_cmd(ACT_SPARE_HI, 32'hffff_ffff,  16'hffff);
    send_cmd(ACT_COUNT,    32'hffff_ffff,  16'hffff);
    send_cmd(ACT_CLEAR,    32'd0,          16'd0);
    send_cmd(ACT_GET,      32'd0,          16'd1);

    // Fill past capacity so full-list refusals are exercised early.
    for (i = 0; i < CAPACITY + 4; i++) begin
      send_cmd((i % 2 == 0) ? ACT_APPEND : ACT_INSERT, pick_value(), pick_position(i));
      rand_sent++;
    end

    while (rand_sent < RANDOM_ITEMS) begin
      ph   = traffic_phase_t'($urandom_range(2));
      span = $urandom_range(120, 40);
      for (i = 0; i < span && rand_sent < RANDOM_ITEMS; i++) begin
        no_idle <= (rand_sent >= 500 && rand_sent < 800);
        send_cmd(pick_action(ph), pick_value(), pick_position(cur_len));
        rand_sent++;
      end
    end
    in_tvalid <= 1'b0;
    no_idle   <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: append %0d, insert %0d, get %0d, remove %0d, count %0d,",
             rand_sent + 25, act_count[ACT_APPEND], act_count[ACT_INSERT],
             act_count[ACT_GET], act_count[ACT_REMOVE], act_count[ACT_COUNT]);
    $display("clear %0d, spare codes %0d; longest list %0d entries; %0d mismatches",
             act_count[ACT_CLEAR], act_count[ACT_SPARE_LO] + act_count[ACT_SPARE_HI],
             peak_len, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
